// ----- design/ogop_pkg.sv -----
// Shared constants and types for the octahedral grid orientation point block.
package ogop_pkg;

    localparam int QW      = 33;            // result bits searched, one per stage
    localparam int DENW    = 48;            // root denominator width (r2 cubed)
    localparam int RHSW    = 67;            // root right-hand side width (2^66)
    localparam int WIDEW   = 120;           // root trial sum width
    localparam int DNUMW   = 33;            // divider numerator width
    localparam int DDENW   = 17;            // divider denominator width
    localparam int DACCW   = 52;            // divider trial product width
    localparam int FRW     = 17;            // Q16 fraction width
    localparam int WTW     = 33;            // Q32 weight width
    localparam int IDXW    = 16;            // point index width
    localparam int CW      = 8;             // lattice coordinate width
    localparam int SQW     = 16;            // squared coordinate width
    localparam int FRONT   = 5;             // stages ahead of the search units
    localparam int NV      = FRONT + QW + 1;
    localparam int Q16_SH  = 34;            // num^2 scale for the Q16 root search
    localparam int TDIW    = 16;
    localparam int TDOW    = 152;

    localparam logic [CW-1:0]   GD_RESET   = 8'd16;
    localparam logic            REG_GRID   = 1'b0;
    localparam logic [RHSW-1:0] WEIGHT_RHS = RHSW'(1) << 66;

    typedef struct packed {
        logic            oor;
        logic            apex;
        logic [IDXW-1:0] pidx;
    } t_side;

endpackage

// ----- design/ogop_root.sv -----
// Pipelined search for the largest m with (2m-1)^2 * den <= rhs, one bit per stage.
module ogop_root (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [ogop_pkg::DENW-1:0]   i_den,
    input  logic [ogop_pkg::RHSW-1:0]   i_rhs,
    output logic [ogop_pkg::QW-1:0]     o_q
);
    import ogop_pkg::*;

    logic [RHSW-1:0] r_m2  [QW];
    logic [RHSW-1:0] r_m1  [QW];
    logic [QW-1:0]   r_q   [QW];
    logic [DENW-1:0] r_den [QW];
    logic [RHSW-1:0] r_rhs [QW];

    genvar s;
    generate
        for (s = 0; s < QW; s++) begin : g_stage
            localparam int K = QW - 1 - s;
            logic [RHSW-1:0]  p_m2, p_m1, p_rhs;
            logic [QW-1:0]    p_q;
            logic [DENW-1:0]  p_den;
            logic [WIDEW-1:0] n_m1, n_m2, w_test;
            logic             w_ok;

            if (s == 0) begin : g_first
                assign p_m2  = '0;
                assign p_m1  = '0;
                assign p_q   = '0;
                assign p_den = i_den;
                assign p_rhs = i_rhs;
            end else begin : g_next
                assign p_m2  = r_m2[s-1];
                assign p_m1  = r_m1[s-1];
                assign p_q   = r_q[s-1];
                assign p_den = r_den[s-1];
                assign p_rhs = r_rhs[s-1];
            end

            // m^2*den and m*den grow by shifts and adds as the trial bit is set
            always_comb begin
                n_m1   = WIDEW'(p_m1) + (WIDEW'(p_den) << K);
                n_m2   = WIDEW'(p_m2) + (WIDEW'(p_m1) << (K + 1)) + (WIDEW'(p_den) << (2 * K));
                w_test = (n_m2 << 2) - (n_m1 << 2) + WIDEW'(p_den);
                w_ok   = (w_test <= WIDEW'(p_rhs));
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_den[s] <= p_den;
                    r_rhs[s] <= p_rhs;
                    if (w_ok) begin
                        r_m2[s] <= n_m2[RHSW-1:0];
                        r_m1[s] <= n_m1[RHSW-1:0];
                        r_q[s]  <= p_q | (QW'(1) << K);
                    end else begin
                        r_m2[s] <= p_m2;
                        r_m1[s] <= p_m1;
                        r_q[s]  <= p_q;
                    end
                end
            end
        end
    endgenerate

    assign o_q = r_q[QW-1];

endmodule

// ----- design/ogop_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module ogop_div (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [ogop_pkg::DNUMW-1:0]   i_num,
    input  logic [ogop_pkg::DDENW-1:0]   i_den,
    output logic [ogop_pkg::FRW-1:0]     o_q
);
    import ogop_pkg::*;

    logic [DACCW-1:0] r_acc [QW];
    logic [QW-1:0]    r_q   [QW];
    logic [DNUMW-1:0] r_num [QW];
    logic [DDENW-1:0] r_den [QW];

    genvar s;
    generate
        for (s = 0; s < QW; s++) begin : g_stage
            localparam int K = QW - 1 - s;
            logic [DACCW-1:0] p_acc, n_acc;
            logic [QW-1:0]    p_q;
            logic [DNUMW-1:0] p_num;
            logic [DDENW-1:0] p_den;
            logic             w_ok;

            if (s == 0) begin : g_first
                assign p_acc = '0;
                assign p_q   = '0;
                assign p_num = i_num;
                assign p_den = i_den;
            end else begin : g_next
                assign p_acc = r_acc[s-1];
                assign p_q   = r_q[s-1];
                assign p_num = r_num[s-1];
                assign p_den = r_den[s-1];
            end

            always_comb begin
                n_acc = p_acc + (DACCW'(p_den) << K);
                w_ok  = (n_acc <= DACCW'(p_num));
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_num[s] <= p_num;
                    r_den[s] <= p_den;
                    if (w_ok) begin
                        r_acc[s] <= n_acc;
                        r_q[s]   <= p_q | (QW'(1) << K);
                    end else begin
                        r_acc[s] <= p_acc;
                        r_q[s]   <= p_q;
                    end
                end
            end
        end
    endgenerate

    assign o_q = r_q[QW-1][FRW-1:0];

endmodule

// ----- design/octahedral_grid_orientation_point_top.sv -----
// Top level of the octahedral grid orientation point pipeline.
// One lattice point (row, col) is accepted every clock unless the result side stalls;
// five front stages form the squares, r2, r2^3 and the linear index, then 33
// stages of bit-per-stage search produce the Q16 fractions, the Q16 cosines and the
// Q32 weight, and one output register holds the result. The 33-bit weight search sets
// that depth. The pipeline advances as a whole whenever the output register is empty
// or taken, so a stall on the result side holds every stage in place.
module octahedral_grid_orientation_point_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [ogop_pkg::TDIW-1:0]     s_axis_tdata,   // row_index, col_index
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // x_sq_frac, y_sq_frac, z_sq_frac, weight, polar_cos, azim_cos, azim_sin,
    // point_index, zero pad
    output logic [ogop_pkg::TDOW-1:0]     m_axis_tdata,
    output logic                          m_axis_tuser,   // out_of_range
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import ogop_pkg::*;

    logic [CW-1:0]  r_gd;
    logic [NV-1:0]  r_vld;
    logic           w_en;

    // configuration
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gd <= GD_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_GRID)) begin
            r_gd <= pwdata[CW-1:0];
        end
    end
    assign prdata = (paddr[2] == REG_GRID) ? {24'd0, r_gd} : 32'd0;

    assign w_en          = !r_vld[NV-1] || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[NV-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NV-2:0], s_axis_tvalid};
        end
    end

    // stage 0: coordinates and range check
    logic [CW-1:0] w_i, w_j;
    logic [CW:0]   w_sum;
    logic [CW-1:0] r0_i, r0_j, r0_a, r0_nt;
    logic          r0_oor;
    assign w_i   = s_axis_tdata[7:0];
    assign w_j   = s_axis_tdata[15:8];
    assign w_sum = {1'b0, w_i} + {1'b0, w_j};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_i   <= w_i;
            r0_j   <= w_j;
            r0_a   <= r_gd - w_i - w_j;
            r0_nt  <= r_gd;
            r0_oor <= (r_gd == '0) || (w_sum > {1'b0, r_gd});
        end
    end

    // stage 1: squares and index products
    logic [SQW-1:0] r1_a2, r1_b2, r1_c2, r1_jj;
    logic [SQW:0]   r1_jn;
    logic [CW-1:0]  r1_i, w_jm1;
    logic           r1_oor;
    assign w_jm1 = (r0_j == '0) ? '0 : r0_j - 8'd1;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_a2  <= r0_a * r0_a;
            r1_b2  <= r0_i * r0_i;
            r1_c2  <= r0_j * r0_j;
            r1_jn  <= (SQW+1)'(r0_j) * (SQW+1)'({1'b0, r0_nt} + 9'd1);
            r1_jj  <= SQW'((SQW'(r0_j) * SQW'(w_jm1)) >> 1);
            r1_i   <= r0_i;
            r1_oor <= r0_oor;
        end
    end

    // stage 2: r2, a^2+b^2, linear index
    logic [SQW-1:0]  r2_r2, r2_ab2, r2_a2, r2_b2, r2_c2;
    logic [IDXW-1:0] r2_pidx;
    logic            r2_oor;
    logic [SQW+1:0]  w_r2;
    logic [SQW:0]    w_ab2, w_pidx;
    assign w_r2   = (SQW+2)'(r1_a2) + (SQW+2)'(r1_b2) + (SQW+2)'(r1_c2);
    assign w_ab2  = (SQW+1)'(r1_a2) + (SQW+1)'(r1_b2);
    assign w_pidx = r1_jn - (SQW+1)'(r1_jj) + (SQW+1)'(r1_i);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_r2   <= w_r2[SQW-1:0];
            r2_ab2  <= w_ab2[SQW-1:0];
            r2_pidx <= w_pidx[IDXW-1:0];
            r2_a2   <= r1_a2;
            r2_b2   <= r1_b2;
            r2_c2   <= r1_c2;
            r2_oor  <= r1_oor;
        end
    end

    // stages 3 and 4: r2^2, then r2^3
    logic [2*SQW-1:0] r3_sq;
    logic [SQW-1:0]   r3_r2, r3_ab2, r3_a2, r3_b2, r3_c2;
    logic [IDXW-1:0]  r3_pidx;
    logic             r3_oor;
    logic [DENW-1:0]  r4_cube;
    logic [SQW-1:0]   r4_r2, r4_ab2, r4_a2, r4_b2, r4_c2;
    t_side            r4_side;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_sq   <= r2_r2 * r2_r2;
            r3_r2   <= r2_r2;
            r3_ab2  <= r2_ab2;
            r3_a2   <= r2_a2;
            r3_b2   <= r2_b2;
            r3_c2   <= r2_c2;
            r3_pidx <= r2_pidx;
            r3_oor  <= r2_oor;
            r4_cube <= DENW'(r3_sq) * DENW'(r3_r2);
            r4_r2   <= r3_r2;
            r4_ab2  <= r3_ab2;
            r4_a2   <= r3_a2;
            r4_b2   <= r3_b2;
            r4_c2   <= r3_c2;
            r4_side <= '{oor: r3_oor, apex: (r3_ab2 == '0), pidx: r3_pidx};
        end
    end

    // search units
    logic [QW-1:0]  w_wt, w_cb, w_ca, w_sa;
    logic [FRW-1:0] w_xf, w_yf, w_zf;

    ogop_root u_root_wt (.i_clk(i_clk), .i_en(w_en), .i_den(r4_cube),
                         .i_rhs(WEIGHT_RHS), .o_q(w_wt));
    ogop_root u_root_cb (.i_clk(i_clk), .i_en(w_en), .i_den(DENW'(r4_r2)),
                         .i_rhs(RHSW'(r4_c2) << Q16_SH), .o_q(w_cb));
    ogop_root u_root_ca (.i_clk(i_clk), .i_en(w_en), .i_den(DENW'(r4_ab2)),
                         .i_rhs(RHSW'(r4_a2) << Q16_SH), .o_q(w_ca));
    ogop_root u_root_sa (.i_clk(i_clk), .i_en(w_en), .i_den(DENW'(r4_ab2)),
                         .i_rhs(RHSW'(r4_b2) << Q16_SH), .o_q(w_sa));

    ogop_div u_div_x (.i_clk(i_clk), .i_en(w_en),
                      .i_num((DNUMW'(r4_a2) << 17) + DNUMW'(r4_r2)),
                      .i_den({r4_r2, 1'b0}), .o_q(w_xf));
    ogop_div u_div_y (.i_clk(i_clk), .i_en(w_en),
                      .i_num((DNUMW'(r4_b2) << 17) + DNUMW'(r4_r2)),
                      .i_den({r4_r2, 1'b0}), .o_q(w_yf));
    ogop_div u_div_z (.i_clk(i_clk), .i_en(w_en),
                      .i_num((DNUMW'(r4_c2) << 17) + DNUMW'(r4_r2)),
                      .i_den({r4_r2, 1'b0}), .o_q(w_zf));

    // sideband delay matching the search depth
    t_side r_sd [QW];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd[0] <= r4_side;
            for (int k = 1; k < QW; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    // output register: zero everything off the face, fix the apex azimuth
    logic [FRW-1:0]  r_o_x, r_o_y, r_o_z, r_o_cb, r_o_ca, r_o_sa;
    logic [WTW-1:0]  r_o_wt;
    logic [IDXW-1:0] r_o_idx;
    logic            r_o_oor;
    t_side           w_last;
    assign w_last = r_sd[QW-1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_oor <= w_last.oor;
            if (w_last.oor) begin
                r_o_x   <= '0;
                r_o_y   <= '0;
                r_o_z   <= '0;
                r_o_wt  <= '0;
                r_o_cb  <= '0;
                r_o_ca  <= '0;
                r_o_sa  <= '0;
                r_o_idx <= '0;
            end else begin
                r_o_x   <= w_xf;
                r_o_y   <= w_yf;
                r_o_z   <= w_zf;
                r_o_wt  <= w_wt;
                r_o_cb  <= w_cb[FRW-1:0];
                r_o_ca  <= w_last.apex ? FRW'(65536) : w_ca[FRW-1:0];
                r_o_sa  <= w_last.apex ? '0 : w_sa[FRW-1:0];
                r_o_idx <= w_last.pidx;
            end
        end
    end

    assign m_axis_tdata = {1'b0, r_o_idx, r_o_sa, r_o_ca, r_o_cb, r_o_wt,
                           r_o_z, r_o_y, r_o_x};
    assign m_axis_tuser = r_o_oor;

`ifndef SYNTHESIS
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("off-face result carries nonzero fields");

    a_frac_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |->
        (((FRW+2)'(r_o_x) + (FRW+2)'(r_o_y) + (FRW+2)'(r_o_z) >= (FRW+2)'(65535)) &&
         ((FRW+2)'(r_o_x) + (FRW+2)'(r_o_y) + (FRW+2)'(r_o_z) <= (FRW+2)'(65537))))
        else $error("squared direction cosines do not sum to one");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");
`endif

endmodule
